>>> design/msf_pkg.sv
// Shared types and constants for the message slot FIFO.
// No dependencies; imported by msf_ctrl, msf_datapath and message_slot_fifo.
`default_nettype none

package msf_pkg;

    localparam int SLOT_BYTES  = 64;
    localparam int SLOT_COUNT  = 16;
    localparam int MAX_RESULTS = 64;
    localparam int LIMIT_CAP   = (SLOT_BYTES < MAX_RESULTS) ? SLOT_BYTES : MAX_RESULTS;

    localparam int LEN_W       = 7;
    localparam int SLOTS_W     = 5;
    localparam int SLOT_AW     = $clog2(SLOT_COUNT);
    localparam int BYTE_AW     = $clog2(SLOT_BYTES);
    localparam int STORE_DEPTH = SLOT_COUNT * SLOT_BYTES;
    localparam int STORE_AW    = SLOT_AW + BYTE_AW;

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_BYTES_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS       = CFG_IDX_W'(1);

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_BYTE     = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_last;
        status_t          status;
        logic [LEN_W-1:0] message_length;
        logic             overflow_seen;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic push;
        logic pop_empty;
        logic pop_start;
        logic len_load;
        logic byte_emit;
        logic pop_finish;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ring_empty;
        logic last_byte;
    } dp_status_t;

endpackage

`default_nettype wire

>>> design/msf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module msf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/msf_ctrl.sv
// Sequencer for the message slot FIFO: accepts items, steps pops byte by byte.
// Depends on msf_pkg.
`default_nettype none

module msf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                mode,
    input  msf_pkg::dp_status_t stat,
    output msf_pkg::ctrl_cmd_t  cmd,
    output logic                busy
);

    import msf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_BYTES
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_PUSH)
                    begin
                        cmd.push = 1'b1;
                    end
                    else if (stat.ring_empty)
                    begin
                        cmd.pop_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.pop_start = 1'b1;
                        state_next    = S_LEN;
                    end
                end
            end
            S_LEN:
            begin
                cmd.len_load = 1'b1;
                state_next   = S_BYTES;
            end
            S_BYTES:
            begin
                cmd.byte_emit = 1'b1;
                if (stat.last_byte)
                begin
                    cmd.pop_finish = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

>>> design/msf_datapath.sv
// Datapath: ring pointers, staging count, config registers, byte and length stores,
// result register. Depends on msf_pkg and msf_ram.
`default_nettype none

module msf_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msf_pkg::ctrl_cmd_t                cmd,
    output msf_pkg::dp_status_t               stat,
    input  msf_pkg::in_t                      item,
    input  logic                              cfg_wr,
    input  logic [msf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [msf_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              result_valid,
    output msf_pkg::out_t                     result
);

    import msf_pkg::*;

    function automatic logic [SLOT_AW-1:0] slot_advance(
        input logic [SLOT_AW-1:0] slot,
        input logic [SLOTS_W-1:0] slots
    );
        logic [SLOTS_W-1:0] inc;
        begin
            inc = SLOTS_W'(slot) + 1'b1;
            slot_advance = (inc == slots) ? '0 : inc[SLOT_AW-1:0];
        end
    endfunction

    logic [LEN_W-1:0]   limit_reg,  limit_next;
    logic [SLOTS_W-1:0] slots_reg,  slots_next;
    logic [SLOT_AW-1:0] ws_reg,     ws_next;
    logic [SLOT_AW-1:0] rs_reg,     rs_next;
    logic [SLOTS_W-1:0] held_reg,   held_next;
    logic [LEN_W-1:0]   staged_reg, staged_next;
    logic               ovf_reg,    ovf_next;
    logic               res_valid_reg, res_valid_next;

    out_t               res_reg,     res_next;
    logic [LEN_W-1:0]   pop_len_reg, pop_len_next;
    logic [BYTE_AW-1:0] idx_reg,     idx_next;

    logic [LEN_W-1:0]   staged_inc;
    logic               ring_full;
    logic               too_long;
    logic               msg_end;
    logic               commit;
    logic               byte_wr;
    logic [BYTE_AW-1:0] rd_idx;
    logic [7:0]         byte_q;
    logic [LEN_W-1:0]   len_q;
    logic [LEN_W-1:0]   cfg_limit;
    logic [SLOTS_W-1:0] cfg_slots;

    // count saturates so overlong messages still report too long
    assign staged_inc = (staged_reg == '1) ? staged_reg : staged_reg + 1'b1;
    assign ring_full  = ((SLOTS_W + 1)'(held_reg) + 1'b1) >= (SLOTS_W + 1)'(slots_reg);
    assign too_long   = staged_inc > limit_reg;
    assign msg_end    = cmd.push && item.end_of_message;
    assign commit     = msg_end && !ring_full && !too_long;
    assign byte_wr    = cmd.push && (staged_reg < limit_reg);
    assign rd_idx     = cmd.len_load ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        cfg_limit = cfg_data[LEN_W-1:0];
        if (cfg_limit < LEN_W'(1))
        begin
            cfg_limit = LEN_W'(1);
        end
        else if (cfg_limit > LEN_W'(LIMIT_CAP))
        begin
            cfg_limit = LEN_W'(LIMIT_CAP);
        end
        cfg_slots = cfg_data[SLOTS_W-1:0];
        if (cfg_slots < SLOTS_W'(2))
        begin
            cfg_slots = SLOTS_W'(2);
        end
        else if (cfg_slots > SLOTS_W'(SLOT_COUNT))
        begin
            cfg_slots = SLOTS_W'(SLOT_COUNT);
        end
    end

    always_comb
    begin
        limit_next     = limit_reg;
        slots_next     = slots_reg;
        ws_next        = ws_reg;
        rs_next        = rs_reg;
        held_next      = held_reg;
        staged_next    = staged_reg;
        ovf_next       = ovf_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        pop_len_next   = pop_len_reg;
        idx_next       = idx_reg;

        if (cmd.push)
        begin
            staged_next = item.end_of_message ? '0 : staged_inc;
        end
        if (msg_end)
        begin
            res_valid_next          = 1'b1;
            res_next.out_byte       = '0;
            res_next.out_last       = 1'b1;
            res_next.message_length = staged_inc;
            if (ring_full)
            begin
                ovf_next        = 1'b1;
                res_next.status = ST_FULL;
            end
            else if (too_long)
            begin
                res_next.status = ST_TOO_LONG;
            end
            else
            begin
                res_next.status = ST_ACCEPTED;
                ws_next         = slot_advance(ws_reg, slots_reg);
                held_next       = held_reg + 1'b1;
            end
            res_next.overflow_seen = ovf_next;
        end

        if (cmd.pop_empty)
        begin
            res_valid_next         = 1'b1;
            res_next.out_byte      = '0;
            res_next.out_last      = 1'b1;
            res_next.status        = ST_EMPTY;
            res_next.message_length = '0;
            res_next.overflow_seen = ovf_reg;
        end

        if (cmd.len_load)
        begin
            pop_len_next = len_q;
            idx_next     = '0;
        end

        if (cmd.byte_emit)
        begin
            res_valid_next          = 1'b1;
            res_next.out_byte       = byte_q;
            res_next.out_last       = stat.last_byte;
            res_next.status         = ST_BYTE;
            res_next.message_length = pop_len_reg;
            res_next.overflow_seen  = ovf_reg;
            idx_next                = idx_reg + 1'b1;
        end

        if (cmd.pop_finish)
        begin
            rs_next   = slot_advance(rs_reg, slots_reg);
            held_next = held_reg - 1'b1;
        end

        // register write re-initializes the ring
        if (cfg_wr && (cfg_index == REG_BYTES_LIMIT || cfg_index == REG_SLOTS))
        begin
            if (cfg_index == REG_BYTES_LIMIT)
            begin
                limit_next = cfg_limit;
            end
            else
            begin
                slots_next = cfg_slots;
            end
            ws_next     = '0;
            rs_next     = '0;
            held_next   = '0;
            staged_next = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LEN_W'(LIMIT_CAP);
            slots_reg     <= SLOTS_W'(SLOT_COUNT);
            ws_reg        <= '0;
            rs_reg        <= '0;
            held_reg      <= '0;
            staged_reg    <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            slots_reg     <= slots_next;
            ws_reg        <= ws_next;
            rs_reg        <= rs_next;
            held_reg      <= held_next;
            staged_reg    <= staged_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        pop_len_reg <= pop_len_next;
        idx_reg     <= idx_next;
    end

    msf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_byte_store (
        .clk     (clk),
        .wr_en   (byte_wr),
        .wr_addr ({ws_reg, staged_reg[BYTE_AW-1:0]}),
        .wr_data (item.data_byte),
        .rd_en   (cmd.len_load || cmd.byte_emit),
        .rd_addr ({rs_reg, rd_idx}),
        .rd_data (byte_q)
    );

    msf_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOT_COUNT)
    ) u_length_store (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (ws_reg),
        .wr_data (staged_inc),
        .rd_en   (cmd.pop_start),
        .rd_addr (rs_reg),
        .rd_data (len_q)
    );

    assign stat.ring_empty = (held_reg == '0);
    assign stat.last_byte  = ((LEN_W'(idx_reg) + 1'b1) == pop_len_reg);

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

>>> design/message_slot_fifo.sv
// Message slot FIFO top level: sequencer plus datapath.
// Depends on msf_pkg, msf_ctrl, msf_datapath, msf_ram.
`default_nettype none

// A push word is taken on the accepting edge; the message's status result, if any,
// shows on the next cycle. A pop keeps busy high from the accepting edge through the
// registered length-store read and then each byte through the single read port of
// the byte store. Its byte results follow one register behind, one per cycle; a
// pop on an empty ring answers on the next cycle. Results are strobed by result_valid
// for exactly one cycle and must be taken as they come. A configuration write to
// either register empties the ring and is taken only while busy and start are both
// low.
module message_slot_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  msf_pkg::in_t                   item,
    output logic                           result_valid,
    output msf_pkg::out_t                  result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [msf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msf_pkg::CFG_DATA_W-1:0] cfg_data
);

    import msf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;
    logic       cfg_wr;

    // a word offered on the same edge takes precedence over a register write
    assign cfg_ready = !busy && !start;
    assign cfg_wr    = cfg_valid && cfg_ready;

    msf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (item.mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    msf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .cfg_wr       (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    // status-only results answer the word accepted on the previous edge
    a_status_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_BYTE) |-> $past(start && !busy))
        else $error("status result without an accepted word");

    // byte results only come out of a pop in progress
    a_byte_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_BYTE) |-> $past(busy))
        else $error("byte result outside a pop");

    // the final byte of a pop coincides with the sequencer returning to idle
    a_last_byte_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_BYTE && result.out_last) |-> !busy)
        else $error("pop still busy after its last byte");
`endif

endmodule

`default_nettype wire
